// ----- src/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants for the pressure compensation unit
// Holds the register indexes, the configuration bundle, the datapath command
// codes and the controller state encoding.
// ----------------------------------------------------------------------------
package btpc_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_SENS     = 3'd0,
    CFG_OFF      = 3'd1,
    CFG_TCS      = 3'd2,
    CFG_TCO      = 3'd3,
    CFG_TREF     = 3'd4,
    CFG_TEMPSENS = 3'd5,
    CFG_VARIANT  = 3'd6
  } cfg_idx_e;

  // Calibration set seen by the datapath
  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] tcs;
    logic [15:0] tco;
    logic [15:0] tref;
    logic [15:0] tempsens;
    logic        variant;
  } cfg_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_T_MUL,
    OP_T_OUT,
    OP_P_TCO,
    OP_P_TCS,
    OP_P_SENS,
    OP_P_LO,
    OP_P_HI,
    OP_P_ACC,
    OP_P_DIFF,
    OP_P_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_OUT,
    ST_P_TCO,
    ST_P_TCS,
    ST_P_SENS,
    ST_P_LO,
    ST_P_HI,
    ST_P_ACC,
    ST_P_DIFF,
    ST_P_OUT
  } state_e;

  localparam int unsigned RawW  = 24;
  localparam int unsigned DtW   = 26;
  localparam int unsigned ValW  = 32;
  localparam int unsigned MulAW = 26;
  localparam int unsigned MulBW = 19;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned CoefW = 36;
  localparam int unsigned AccW  = 61;
  localparam int unsigned DiffW = 41;

endpackage

// ----- src/btpc_cfg.sv -----
// ----------------------------------------------------------------------------
// btpc_cfg: calibration register file
// Takes register writes by index; an index beyond the list is dropped.
// ----------------------------------------------------------------------------
module btpc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output btpc_pkg::cfg_t     cfg_o
);
  import btpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SENS:     cfg_d.sens     = cfg_data_i;
        CFG_OFF:      cfg_d.off      = cfg_data_i;
        CFG_TCS:      cfg_d.tcs      = cfg_data_i;
        CFG_TCO:      cfg_d.tco      = cfg_data_i;
        CFG_TREF:     cfg_d.tref     = cfg_data_i;
        CFG_TEMPSENS: cfg_d.tempsens = cfg_data_i;
        CFG_VARIANT:  cfg_d.variant  = cfg_data_i[0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  a_variant_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == CFG_VARIANT) |=> cfg_q.variant == $past(cfg_data_i[0]))
    else $error("variant register missed a write");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == 3'd7) |=> cfg_q == $past(cfg_q))
    else $error("write beyond the register list changed a register");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> cfg_q == $past(cfg_q))
    else $error("register changed without a write");

endmodule

// ----- src/btpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// btpc_ctrl: sequencing state machine
// Accepts one conversion at a time and steps the datapath through the
// temperature or pressure schedule, waiting for a free output register.
// ----------------------------------------------------------------------------
module btpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           func_i,
  input  btpc_pkg::sts_t sts_i,
  output btpc_pkg::cmd_t cmd_o
);
  import btpc_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = func_i ? ST_P_TCO : ST_T_MUL;
        end
      end
      ST_T_MUL:  state_d = ST_T_OUT;
      ST_T_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_P_TCO:  state_d = ST_P_TCS;
      ST_P_TCS:  state_d = ST_P_SENS;
      ST_P_SENS: state_d = ST_P_LO;
      ST_P_LO:   state_d = ST_P_HI;
      ST_P_HI:   state_d = ST_P_ACC;
      ST_P_ACC:  state_d = ST_P_DIFF;
      ST_P_DIFF: state_d = ST_P_OUT;
      ST_P_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_T_MUL:  cmd_o.op = OP_T_MUL;
      ST_T_OUT:  cmd_o.op = sts_i.out_free ? OP_T_OUT : OP_NONE;
      ST_P_TCO:  cmd_o.op = OP_P_TCO;
      ST_P_TCS:  cmd_o.op = OP_P_TCS;
      ST_P_SENS: cmd_o.op = OP_P_SENS;
      ST_P_LO:   cmd_o.op = OP_P_LO;
      ST_P_HI:   cmd_o.op = OP_P_HI;
      ST_P_ACC:  cmd_o.op = OP_P_ACC;
      ST_P_DIFF: cmd_o.op = OP_P_DIFF;
      ST_P_OUT:  cmd_o.op = sts_i.out_free ? OP_P_OUT : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_pres_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i) |=> state_q == ST_P_TCO)
    else $error("pressure transaction did not start the pressure schedule");

  a_temp_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !func_i) |=> state_q == ST_T_MUL)
    else $error("temperature transaction did not start the temperature schedule");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_P_OUT || state_q == ST_T_OUT) && !sts_i.out_free) |=>
      state_q == $past(state_q))
    else $error("left the result state while the output register was full");

endmodule

// ----- src/btpc_datapath.sv -----
// ----------------------------------------------------------------------------
// btpc_datapath: compensation arithmetic
// One shared signed 26x19 multiplier with a registered product, coefficient
// and accumulator registers, the kept dT and the output register.
// ----------------------------------------------------------------------------
module btpc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  btpc_pkg::cfg_t               cfg_i,
  input  btpc_pkg::cmd_t               cmd_i,
  output btpc_pkg::sts_t               sts_o,
  input  logic                         func_i,
  input  logic [btpc_pkg::RawW-1:0]    raw_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic signed [btpc_pkg::ValW-1:0] value_o
);
  import btpc_pkg::*;

  logic                     func_q, func_d;
  logic [RawW-1:0]          raw_q, raw_d;
  logic signed [DtW-1:0]    last_dt_q, last_dt_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [CoefW-1:0]  off_q, off_d;
  logic signed [CoefW-1:0]  sens_q, sens_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [DiffW-1:0]  diff_q, diff_d;
  logic                     out_valid_q, out_valid_d;
  logic                     kind_q, kind_d;
  logic signed [ValW-1:0]   value_q, value_d;

  logic signed [DtW-1:0]    dt_calc;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [ProdW-1:0]  temp_rnd;
  logic signed [ProdW-1:0]  temp_val;
  logic signed [ProdW-1:0]  off_rnd;
  logic signed [ProdW-1:0]  off_term;
  logic signed [CoefW-1:0]  off_base;
  logic signed [ProdW-1:0]  sens_rnd;
  logic signed [ProdW-1:0]  sens_term;
  logic signed [CoefW-1:0]  sens_base;
  logic signed [AccW-1:0]   prod_ext;
  logic signed [AccW-1:0]   acc_rnd;
  logic signed [AccW-1:0]   acc_sh;
  logic signed [DiffW-1:0]  diff_rnd;
  logic signed [DiffW-1:0]  pres_val;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign value_o        = value_q;

  // Difference to the reference temperature
  assign dt_calc = $signed({2'b00, raw_q}) - $signed({2'b00, cfg_i.tref, 8'h00});

  // Select multiplier operands
  always_comb begin
    mul_a = last_dt_q;
    mul_b = $signed({3'b000, cfg_i.tco});
    case (cmd_i.op)
      OP_T_MUL: begin
        mul_a = dt_calc;
        mul_b = $signed({3'b000, cfg_i.tempsens});
      end
      OP_P_TCO: begin
        mul_a = last_dt_q;
        mul_b = $signed({3'b000, cfg_i.tco});
      end
      OP_P_TCS: begin
        mul_a = last_dt_q;
        mul_b = $signed({3'b000, cfg_i.tcs});
      end
      OP_P_LO: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = $signed({1'b0, sens_q[17:0]});
      end
      OP_P_HI: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = $signed({sens_q[CoefW-1], sens_q[CoefW-1:18]});
      end
      default: begin
        mul_a = last_dt_q;
        mul_b = $signed({3'b000, cfg_i.tco});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Temperature: 2000 + dT*tempsens/2^23, truncated toward zero
  assign temp_rnd = prod_q + (prod_q[ProdW-1] ? 45'sd8388607 : 45'sd0);
  assign temp_val = (temp_rnd >>> 23) + 45'sd2000;

  // Offset: coef_off scaled plus tco*dT scaled down, truncated toward zero
  assign off_rnd  = prod_q + (prod_q[ProdW-1] ? (cfg_i.variant ? 45'sd127 : 45'sd63) : 45'sd0);
  assign off_term = cfg_i.variant ? (off_rnd >>> 7) : (off_rnd >>> 6);
  assign off_base = cfg_i.variant ? $signed({4'h0, cfg_i.off, 16'h0000})
                                  : $signed({3'b000, cfg_i.off, 17'h00000});

  // Sensitivity: coef_sens scaled plus tcs*dT scaled down
  assign sens_rnd  = prod_q + (prod_q[ProdW-1] ? (cfg_i.variant ? 45'sd255 : 45'sd127)
                                               : 45'sd0);
  assign sens_term = cfg_i.variant ? (sens_rnd >>> 8) : (sens_rnd >>> 7);
  assign sens_base = cfg_i.variant ? $signed({5'h00, cfg_i.sens, 15'h0000})
                                   : $signed({4'h0, cfg_i.sens, 16'h0000});

  // Pressure: (raw*SENS/2^21 - OFF)/2^15, each step truncated toward zero
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign acc_rnd  = acc_q + (acc_q[AccW-1] ? 61'sd2097151 : 61'sd0);
  assign acc_sh   = acc_rnd >>> 21;
  assign diff_rnd = diff_q + (diff_q[DiffW-1] ? 41'sd32767 : 41'sd0);
  assign pres_val = diff_rnd >>> 15;

  // Register updates per command
  always_comb begin
    func_d      = func_q;
    raw_d       = raw_q;
    last_dt_d   = last_dt_q;
    prod_d      = mul_p;
    off_d       = off_q;
    sens_d      = sens_q;
    acc_d       = acc_q;
    diff_d      = diff_q;
    kind_d      = kind_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i.op)
      // Hold the product while a result waits for the output register
      OP_NONE:   prod_d = prod_q;
      OP_LOAD: begin
        func_d = func_i;
        raw_d  = raw_sample_i;
      end
      OP_T_MUL: last_dt_d = dt_calc;
      OP_T_OUT: begin
        kind_d      = func_q;
        value_d     = temp_val[ValW-1:0];
        out_valid_d = 1'b1;
      end
      OP_P_TCS:  off_d  = off_base + $signed(off_term[CoefW-1:0]);
      OP_P_SENS: sens_d = sens_base + $signed(sens_term[CoefW-1:0]);
      OP_P_HI:   acc_d  = prod_ext;
      OP_P_ACC:  acc_d  = acc_q + $signed({prod_ext[AccW-19:0], 18'h00000});
      OP_P_DIFF: diff_d = $signed(acc_sh[DiffW-1:0])
                          - $signed({{(DiffW-CoefW){off_q[CoefW-1]}}, off_q});
      OP_P_OUT: begin
        kind_d      = func_q;
        value_d     = pres_val[ValW-1:0];
        out_valid_d = 1'b1;
      end
      default: begin
        func_d = func_q;
      end
    endcase
  end

  // Control state and kept dT
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_dt_q   <= last_dt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    raw_q   <= raw_d;
    prod_q  <= prod_d;
    off_q   <= off_d;
    sens_q  <= sens_d;
    acc_q   <= acc_d;
    diff_q  <= diff_d;
    kind_q  <= kind_d;
    value_q <= value_d;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_i.op == OP_T_OUT || cmd_i.op == OP_P_OUT))
    else $error("output register loaded over a waiting result");

  a_dt_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != OP_T_MUL) |=> $stable(last_dt_q))
    else $error("kept dT changed outside a temperature transaction");

  a_kind_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_P_OUT) |=> kind_q)
    else $error("pressure result tagged as temperature");

endmodule

// ----- src/baro_temp_pressure_compensation_unit.sv -----
// Sequence: a temperature result passes through the registered product to the
// output register; a pressure result first steps the shared 26x19 multiplier through
// the TCO, TCS, SENS, LO, HI, ACC and DIFF states. Both wait while the output is full.
// Input: one conversion at a time, accepted only in idle; a new item is also
// accepted while a finished result waits on the output. Reset: asynchronous,
// active low; clears the calibration registers, the state, the kept dT and the output valid.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit: first-order sensor compensation
// Turns raw temperature and pressure conversions into 0.01 degC and Pa.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [btpc_pkg::RawW-1:0]        raw_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic signed [btpc_pkg::ValW-1:0] value_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [2:0]                       cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);
  import btpc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Calibration registers
  btpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer
  btpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register
  btpc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o)
  );

endmodule

// ----- bench/baro_temp_pressure_compensation_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit_tb: self-checking bench
// Drives raw temperature and pressure conversions under several calibration
// sets and both scaling variants. Every result is compared with an in-bench
// computation of the first-order compensation, with random gaps on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_tb;
  import btpc_pkg::*;

  localparam logic        FuncTemp    = 1'b0;
  localparam logic        FuncPres    = 1'b1;
  localparam logic [2:0]  CfgIdxSpare = 3'd7;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseItems  = 275;
  localparam int unsigned HoldCycles  = 400;

  typedef struct packed {
    logic            func;
    logic [RawW-1:0] raw;
  } sample_t;

  typedef struct packed {
    logic                   kind;
    logic signed [ValW-1:0] value;
  } reading_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic                   func_i       = FuncTemp;
  logic [RawW-1:0]        raw_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic                   kind_o;
  logic signed [ValW-1:0] value_o;
  logic                   cfg_valid_i  = 1'b0;
  logic                   cfg_ready_o;
  logic [2:0]             cfg_index_i  = '0;
  logic [15:0]            cfg_data_i   = '0;

  // Calibration and kept temperature difference as the bench sees them
  cfg_t                   cal = '0;
  logic signed [DtW-1:0]  kept_dt = '0;

  sample_t     pending_samples[$];
  reading_t    expected_results[$];
  bit          sample_taken = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  baro_temp_pressure_compensation_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Compensate one conversion; a temperature conversion refreshes kept_dt
  function automatic reading_t compensate_sample(logic func, logic [RawW-1:0] raw);
    longint   r, d, t, off, sens, p;
    reading_t res;
    r = raw;
    res.kind = func;
    if (func == FuncTemp) begin
      d = r - longint'(cal.tref) * 256;
      kept_dt = d[DtW-1:0];
      t = 2000 + (d * longint'(cal.tempsens)) / 8388608;
      res.value = t[ValW-1:0];
    end else begin
      d = kept_dt;
      if (cal.variant == 1'b0) begin
        off  = longint'(cal.off) * 131072 + (longint'(cal.tco) * d) / 64;
        sens = longint'(cal.sens) * 65536 + (longint'(cal.tcs) * d) / 128;
      end else begin
        off  = longint'(cal.off) * 65536 + (longint'(cal.tco) * d) / 128;
        sens = longint'(cal.sens) * 32768 + (longint'(cal.tcs) * d) / 256;
      end
      p = (r * sens / 2097152 - off) / 32768;
      res.value = p[ValW-1:0];
    end
    return res;
  endfunction

  // Mirror a register write; unknown indexes are dropped
  function automatic void mirror_register(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_SENS:     cal.sens     = data;
      CFG_OFF:      cal.off      = data;
      CFG_TCS:      cal.tcs      = data;
      CFG_TCO:      cal.tco      = data;
      CFG_TREF:     cal.tref     = data;
      CFG_TEMPSENS: cal.tempsens = data;
      CFG_VARIANT:  cal.variant  = data[0];
      default: ;
    endcase
  endfunction

  // Mostly conversions around the reference point, with edges and noise
  function automatic sample_t random_sample();
    sample_t         s;
    logic [RawW-1:0] centre;
    int unsigned     pick;
    centre = {cal.tref, 8'h00};
    pick = $urandom_range(19, 0);
    s.func = ($urandom_range(9, 0) < 6) ? FuncPres : FuncTemp;
    case (pick)
      0:       s.raw = '0;
      1:       s.raw = '1;
      2:       s.raw = centre;
      3, 4, 5: s.raw = RawW'($urandom);
      default: s.raw = centre + RawW'($urandom_range(262143, 0)) - RawW'(131072);
    endcase
    return s;
  endfunction

  task automatic write_register(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_calibration(logic [15:0] sens, logic [15:0] off,
                                     logic [15:0] tcs, logic [15:0] tco,
                                     logic [15:0] tref, logic [15:0] tempsens,
                                     logic [15:0] variant);
    write_register(CFG_SENS, sens);
    write_register(CFG_OFF, off);
    write_register(CFG_TCS, tcs);
    write_register(CFG_TCO, tco);
    write_register(CFG_TREF, tref);
    write_register(CFG_TEMPSENS, tempsens);
    write_register(CFG_VARIANT, variant);
  endtask

  task automatic queue_sample(logic func, logic [RawW-1:0] raw);
    sample_t s;
    s.func = func;
    s.raw  = raw;
    pending_samples.push_back(s);
  endtask

  // Hold until every transaction is through, then let the pipeline settle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, reading_t want, reading_t got);
    error_count++;
    if (error_count <= 10)
      $display("%s: expected kind %0d value %0d, got kind %0d value %0d",
               what, want.kind, want.value, got.kind, got.value);
  endtask

  // Offer pending conversions, with random gaps outside the quiet phase
  always @(negedge clk_i) begin : drive_samples
    sample_t nxt;
    if (rst_ni && (!in_valid_i || sample_taken)) begin
      if (pending_samples.size() != 0 && (quiet || $urandom_range(99, 0) >= 9)) begin
        nxt = pending_samples.pop_front();
        in_valid_i   <= 1'b1;
        func_i       <= nxt.func;
        raw_sample_i <= nxt.raw;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    sample_taken = 1'b0;
  end

  // Stall the output at random; once, hold it off long enough to back up the input
  always @(negedge clk_i) begin : drive_stall
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && results_seen >= 200) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99, 0) < 9);
    end
  end

  // Record accepted conversions and check accepted results
  always @(posedge clk_i) begin : check_results
    reading_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(compensate_sample(func_i, raw_sample_i));
        sample_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.kind  = kind_o;
        got.value = value_o;
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value)
            report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned p;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Typical calibration; pressure arrives before any temperature
    program_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464,
                        16'd28312, 16'd0);
    write_register(CfgIdxSpare, 16'hFFFF);
    queue_sample(FuncPres, 24'hFFFFFF);
    queue_sample(FuncPres, 24'h000000);
    queue_sample(FuncTemp, 24'h000000);
    queue_sample(FuncTemp, 24'hFFFFFF);
    queue_sample(FuncPres, 24'hFFFFFF);
    queue_sample(FuncPres, 24'h000000);
    queue_sample(FuncTemp, {16'd33464, 8'h00});
    queue_sample(FuncPres, 24'h800000);
    queue_sample(FuncTemp, {16'd33464, 8'h00} - 24'd1);
    queue_sample(FuncTemp, 24'hAAAAAA);
    queue_sample(FuncPres, 24'h555555);
    queue_sample(FuncTemp, 24'h555555);
    queue_sample(FuncPres, 24'hAAAAAA);
    wait_drained();

    // Every coefficient at full scale, second variant, spare variant bits set
    program_calibration('1, '1, '1, '1, '1, '1, 16'hFFFF);
    queue_sample(FuncTemp, 24'h000000);
    queue_sample(FuncPres, 24'hFFFFFF);
    queue_sample(FuncPres, 24'h000000);
    queue_sample(FuncTemp, 24'hFFFFFF);
    queue_sample(FuncPres, 24'hFFFFFF);
    queue_sample(FuncTemp, 24'hFFFF00);
    queue_sample(FuncPres, 24'h123456);
    wait_drained();

    // Random conversions under a spread of calibration sets
    for (p = 0; p < RandPhases; p++) begin
      case (p)
        0: program_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'd0);
        1: program_calibration('0, '0, '0, '0, '0, '0, 16'd0);
        2: program_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842,
                               16'd31553, 16'd28165, 16'd1);
        4: program_calibration('1, '1, '1, '1, '1, '1, 16'hFFFE);
        default: program_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom));
      endcase
      quiet = (p == 3);
      repeat (PhaseItems) pending_samples.push_back(random_sample());
      wait_drained();
      quiet = 1'b0;
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
